// ===== hdl/smatch_pkg.sv =====
// Package for the stable matching engine: action codes, widths and defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package smatch_pkg;
  localparam int MaxPeopleDefault = 16;
  localparam int ResultLimit = 16;
  localparam int CountW = 5;
  localparam int IdxW = 4;
  localparam logic [CountW-1:0] CountReset = 5'd16;
  typedef enum logic [1:0] {
    ACT_LOAD_MAN   = 2'd0,
    ACT_LOAD_WOMAN = 2'd1,
    ACT_RUN        = 2'd2,
    ACT_NONE       = 2'd3
  } action_t;
endpackage
`default_nettype wire

// ===== hdl/smatch_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module smatch_ram #(
  parameter int Width = 4,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/stable_matching_engine.sv =====
// Top level of the stable matching engine: preference memories and the proposal sequencer.
// Depends on smatch_pkg and smatch_ram.
//
// Channel  | Direction | Handshake              | Payload
// command  | in        | start & !busy          | action, person, rank, choice
// config   | in        | cfg_valid & cfg_ready  | cfg_data (people_count)
// result   | out       | done strobe, one cycle | index, wife_men_propose,
//          |           |                        | husband_women_propose, unique_flag, last
//
// busy never rises for a load transaction.
// A run transaction walks proposals through one shared read-and-compare step. Each matching
// has a setup state and a new-proposer state per proposer start. A proposal to a partner at
// or above the count reads the preference only; one to a free partner adds a rank read, and
// one to a taken partner adds a second rank read and a compare; a used-up list ends the
// proposer. At most n*n proposals per matching, then an inversion pass, a comparison step
// and n results. busy drops in the cycle that shows the last result.
// Reset is synchronous; holder tables are cleared at the start of every run, so no clearing
// pass runs after reset. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module stable_matching_engine
  import smatch_pkg::*;
#(
  parameter int MAX_PEOPLE = MaxPeopleDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        action,
  input  wire logic [IdxW-1:0]   person,
  input  wire logic [IdxW-1:0]   rank,
  input  wire logic [IdxW-1:0]   choice,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CountW-1:0] cfg_data,
  output logic                   done,
  output logic [IdxW-1:0]        index,
  output logic [IdxW-1:0]        wife_men_propose,
  output logic [IdxW-1:0]        husband_women_propose,
  output logic                   unique_flag,
  output logic                   last
);
  // Effective count limit: smaller of MAX_PEOPLE and the result limit.
  localparam int Lim = (MAX_PEOPLE < ResultLimit) ? MAX_PEOPLE : ResultLimit;
  localparam int PW = $clog2(Lim);
  localparam int AW = 2 * PW;
  localparam int Depth = 1 << AW;
  // When MAX_PEOPLE covers every rank code, no load is dropped for its rank.
  localparam bit RankAny = (MAX_PEOPLE >= (1 << IdxW));

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_NEXTP, S_RDPREF, S_WAITPREF, S_RDRANK, S_WAITRANK, S_DECIDE,
    S_CMP, S_OUT
  } state_t;

  state_t state;
  logic [CountW-1:0] people_count;
  logic [CountW-1:0] n;
  logic              pass;      // 0 men propose, 1 women propose
  logic [CountW-1:0] p;         // outer proposer loop
  logic [IdxW-1:0]   cur, acc, held;
  logic [CountW-1:0] cnt;
  logic              same;
  logic [IdxW-1:0]   hold_m [Lim];
  logic              hold_m_v [Lim];
  logic [IdxW-1:0]   hold_w [Lim];
  logic              hold_w_v [Lim];
  logic [CountW-1:0] nextp [Lim];
  logic [IdxW-1:0]   wife [Lim];
  logic              wife_ok [Lim];
  logic [IdxW-1:0]   husb [Lim];
  logic              husb_ok [Lim];
  logic [IdxW-1:0]   rank_cur;

  // Load decode. Entries for people or positions at or above Lim are never read by a run,
  // so they are dropped; the inverse table keeps the full rank range only when RankAny is set.
  logic load_ok, ld_m, ld_w, pos_ok, rk_ok, ch_ok;
  always_comb begin
    load_ok = start && !busy && ({1'b0, person} < CountW'(Lim));
    ld_m = load_ok && (action == ACT_LOAD_MAN);
    ld_w = load_ok && (action == ACT_LOAD_WOMAN);
    pos_ok = ({1'b0, rank} < CountW'(Lim));
    rk_ok = RankAny || pos_ok;
    ch_ok = ({1'b0, choice} < CountW'(Lim));
  end

  logic [AW-1:0] a_pr, a_pc;
  assign a_pr = {person[PW-1:0], rank[PW-1:0]};
  assign a_pc = {person[PW-1:0], choice[PW-1:0]};

  // Shared read addresses
  logic [AW-1:0] pref_ra, rank_ra;
  logic [IdxW-1:0] mp_q, wp_q, mr_q, wr_q;
  logic [IdxW-1:0] pref_q, rank_q;
  logic [IdxW-1:0] rd_who;
  assign pref_ra = {cur[PW-1:0], nextp[cur[PW-1:0]][PW-1:0]};
  assign rank_ra = {acc[PW-1:0], rd_who[PW-1:0]};
  assign pref_q = pass ? wp_q : mp_q;
  assign rank_q = pass ? mr_q : wr_q;

  smatch_ram #(.Width(IdxW), .Depth(Depth)) u_mp (
    .clk(clk), .we(ld_m && pos_ok), .waddr(a_pr), .wdata(choice), .raddr(pref_ra),
    .rdata(mp_q));
  smatch_ram #(.Width(IdxW), .Depth(Depth)) u_wp (
    .clk(clk), .we(ld_w && pos_ok), .waddr(a_pr), .wdata(choice), .raddr(pref_ra),
    .rdata(wp_q));
  smatch_ram #(.Width(IdxW), .Depth(Depth)) u_mr (
    .clk(clk), .we(ld_m && rk_ok && ch_ok), .waddr(a_pc), .wdata(rank), .raddr(rank_ra),
    .rdata(mr_q));
  smatch_ram #(.Width(IdxW), .Depth(Depth)) u_wr (
    .clk(clk), .we(ld_w && rk_ok && ch_ok), .waddr(a_pc), .wdata(rank), .raddr(rank_ra),
    .rdata(wr_q));

  // Currently held by acceptor in the active pass.
  logic acc_v;
  logic [IdxW-1:0] acc_h;
  always_comb begin
    acc_v = pass ? hold_w_v[acc[PW-1:0]] : hold_m_v[acc[PW-1:0]];
    acc_h = pass ? hold_w[acc[PW-1:0]] : hold_m[acc[PW-1:0]];
  end
  assign rd_who = (state == S_RDRANK) ? cur : held;

  // The two matchings differ if any man in use has a different partner, or is matched in
  // one and unmatched in the other.
  logic differ;
  always_comb begin
    differ = 1'b0;
    for (int i = 0; i < Lim; i++) begin
      if (CountW'(i) < n) begin
        if (wife_ok[i] != hold_w_v[i]) differ = 1'b1;
        else if (wife_ok[i] && wife[i] != hold_w[i]) differ = 1'b1;
      end
    end
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      people_count <= CountReset;
      done <= 1'b0;
      for (int i = 0; i < Lim; i++) begin
        hold_m_v[i] <= 1'b0;
        hold_w_v[i] <= 1'b0;
        nextp[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        people_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start && action == ACT_RUN) begin
            priority if (people_count == '0) n <= CountW'(1);
            else if (people_count > CountW'(Lim)) n <= CountW'(Lim);
            else n <= people_count;
            pass <= 1'b0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          for (int i = 0; i < Lim; i++) begin
            nextp[i] <= '0;
            if (!pass) begin
              hold_m_v[i] <= 1'b0;
              hold_w_v[i] <= 1'b0;
            end
          end
          p <= '0;
          state <= S_NEXTP;
        end
        S_NEXTP: begin
          if (p == n) begin
            if (pass) begin
              cnt <= '0;
              for (int i = 0; i < Lim; i++) begin
                wife_ok[i] <= 1'b0;
                husb_ok[i] <= 1'b0;
              end
              state <= S_CMP;
            end else begin
              pass <= 1'b1;
              state <= S_INIT;
            end
          end else begin
            cur <= p[IdxW-1:0];
            p <= p + 1'b1;
            state <= S_RDPREF;
          end
        end
        S_RDPREF: begin
          // Proposer's list may be exhausted.
          if (nextp[cur[PW-1:0]] >= n) begin
            state <= S_NEXTP;
          end else begin
            nextp[cur[PW-1:0]] <= nextp[cur[PW-1:0]] + 1'b1;
            state <= S_WAITPREF;
          end
        end
        S_WAITPREF: begin
          acc <= pref_q;
          if ({1'b0, pref_q} >= n) begin
            state <= S_RDPREF;
          end else begin
            state <= S_RDRANK;
          end
        end
        S_RDRANK: begin
          if (!acc_v) begin
            if (pass) begin
              hold_w_v[acc[PW-1:0]] <= 1'b1;
              hold_w[acc[PW-1:0]] <= cur;
            end else begin
              hold_m_v[acc[PW-1:0]] <= 1'b1;
              hold_m[acc[PW-1:0]] <= cur;
            end
            state <= S_NEXTP;
          end else begin
            held <= acc_h;
            state <= S_WAITRANK;
          end
        end
        S_WAITRANK: begin
          rank_cur <= rank_q;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (rank_cur < rank_q) begin
            if (pass) hold_w[acc[PW-1:0]] <= cur;
            else hold_m[acc[PW-1:0]] <= cur;
            cur <= held;
          end
          state <= S_RDPREF;
        end
        S_CMP: begin
          // Invert both holder tables, one acceptor a cycle.
          if (cnt == n) begin
            cnt <= '0;
            state <= S_OUT;
          end else begin
            if (hold_m_v[cnt[PW-1:0]]) begin
              wife[hold_m[cnt[PW-1:0]][PW-1:0]] <= cnt[IdxW-1:0];
              wife_ok[hold_m[cnt[PW-1:0]][PW-1:0]] <= 1'b1;
            end
            if (hold_w_v[cnt[PW-1:0]]) begin
              husb[hold_w[cnt[PW-1:0]][PW-1:0]] <= cnt[IdxW-1:0];
              husb_ok[hold_w[cnt[PW-1:0]][PW-1:0]] <= 1'b1;
            end
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT: begin
          if (cnt == '0) begin
            same <= !differ;
            cnt <= cnt + 1'b1;
          end else begin
            done <= 1'b1;
            index <= IdxW'(cnt - 1'b1);
            wife_men_propose <= wife_ok[cnt[PW-1:0] - 1'b1] ? wife[cnt[PW-1:0] - 1'b1] : '0;
            husband_women_propose <= husb_ok[cnt[PW-1:0] - 1'b1] ?
                                     husb[cnt[PW-1:0] - 1'b1] : '0;
            unique_flag <= same;
            last <= (cnt == n);
            cnt <= cnt + 1'b1;
            if (cnt == n) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/smatch_checker.sv =====
// Port-level checker for the stable matching engine, bound to the top level.
// Depends on stable_matching_engine ports only.
`timescale 1ns / 1ps
`default_nettype none
module smatch_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic cfg_ready,
  input wire logic done,
  input wire logic last
);
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    done && last |-> !busy) else $error("busy after last result");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> busy) else $error("result outside run");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == !busy) else $error("config ready while busy");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !busy && !done) else $error("not idle after reset");
endmodule
bind stable_matching_engine smatch_checker u_chk (
  .clk(clk), .rst(rst), .busy(busy), .cfg_ready(cfg_ready),
  .done(done), .last(last));
`default_nettype wire
